@@ hw/rtl/dcse_pkg.sv @@
// Shared types, codes and constants of the digit cursor setpoint editor.
// No dependencies; used by digit_cursor_setpoint_editor.
`timescale 1ns / 1ps

package dcse_pkg;

  localparam int unsigned MAX_DIGITS = 16;
  localparam logic [63:0] MAG_MAX_POS = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] INT32_MAG_MIN = 64'h0000_0000_8000_0000;
  localparam logic [3:0] RENDER_STEPS = 4'd10;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_LEFT  = 3'd1,
    CMD_RIGHT = 3'd2,
    CMD_UP    = 3'd3,
    CMD_DOWN  = 3'd4,
    CMD_END   = 3'd5,
    CMD_SET   = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    REG_VOLT_DEC  = 3'd0,
    REG_AMP_DEC   = 3'd1,
    REG_VOLT_LO   = 3'd2,
    REG_VOLT_HI   = 3'd3,
    REG_AMP_LO    = 3'd4,
    REG_AMP_HI    = 3'd5,
    REG_POWER_CAP = 3'd6,
    REG_MIN_INT   = 3'd7
  } reg_e;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_EXEC  = 12'b0000_0000_0010,
    ST_LIMIT = 12'b0000_0000_0100,
    ST_CSCL  = 12'b0000_0000_1000,
    ST_CMUL  = 12'b0000_0001_0000,
    ST_CCHK  = 12'b0000_0010_0000,
    ST_CDIV  = 12'b0000_0100_0000,
    ST_CSAT  = 12'b0000_1000_0000,
    ST_RLOOP = 12'b0001_0000_0000,
    ST_RFIN  = 12'b0010_0000_0000,
    ST_PROD  = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } state_e;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [63:0] pow10(input logic [4:0] n);
    logic [63:0] p;
    case (n)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      5'd19:   p = 64'd10000000000000000000;
      default: p = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/dcse_if.sv @@
// Valid/ready channel interfaces: key command, result and register write.
// Depends on nothing; used by digit_cursor_setpoint_editor.
`timescale 1ns / 1ps

interface dcse_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic               channel;
  logic signed [31:0] new_value;
  modport source (output valid, command, channel, new_value, input ready);
  modport sink (input valid, command, channel, new_value, output ready);
endinterface

interface dcse_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] volt_value;
  logic signed [31:0] amp_value;
  logic signed [63:0] power_product;
  logic               is_editing;
  logic               edited_channel;
  logic [3:0]         cursor_digit;
  logic [4:0]         digit_total;
  logic [3:0]         step_exponent;
  modport source (output valid, volt_value, amp_value, power_product, is_editing,
                  edited_channel, cursor_digit, digit_total, step_exponent,
                  input ready);
  modport sink (input valid, volt_value, amp_value, power_product, is_editing,
                edited_channel, cursor_digit, digit_total, step_exponent,
                output ready);
endinterface

interface dcse_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/dcse_div.sv @@
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Depends on nothing; used by the power cap clamp of the top level.
`timescale 1ns / 1ps

module dcse_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic [63:0] q_q, q_d;
  logic [31:0] r_q, r_d;
  logic [31:0] d_q, d_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] r_shift;

  always_comb begin
    q_d     = q_q;
    r_d     = r_q;
    d_d     = d_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    r_shift = {r_q, q_q[63]};
    if (start_i) begin
      q_d    = dividend_i;
      r_d    = 32'd0;
      d_d    = divisor_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == 7'd0) begin
        busy_d = 1'b0;
      end else begin
        if (r_shift >= {1'b0, d_q}) begin
          r_d = 32'(r_shift - {1'b0, d_q});
          q_d = {q_q[62:0], 1'b1};
        end else begin
          r_d = r_shift[31:0];
          q_d = {q_q[62:0], 1'b0};
        end
        cnt_d = cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q    <= '0;
      r_q    <= '0;
      d_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      q_q    <= q_d;
      r_q    <= r_d;
      d_q    <= d_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign done_o     = busy_q && (cnt_q == 7'd0);
  assign quotient_o = q_q;

endmodule

@@ hw/rtl/digit_cursor_setpoint_editor.sv @@
// Top level of the digit cursor setpoint editor: sequencer, setpoint state, shared multiplier.
// Depends on dcse_pkg, dcse_if and dcse_div.
`timescale 1ns / 1ps
//
// Usage:
//   cmd_i  - key command transactions (command, channel, new_value).
//   res_o  - one result transaction per command: both setpoints, their raw
//            product and the cursor of the channel under edit.
//   cfg_i  - register writes (index, data); always ready. Write only while idle.
// States of each command, from accept to result valid:
//   cursor move, end edit, no-op commands: EXEC, PROD, DONE.
//   start edit: EXEC, the 10-step digit count of the value (RLOOP), RFIN,
//   PROD, DONE. Step / set value: EXEC, LIMIT, then RLOOP onward as for start
//   edit; the power cap check adds CSCL (scaling by the decimals sum), CMUL and
//   CCHK, and CDIV and CSAT when the value is cut back by the bit-serial divider.
// One command is in flight at a time; cmd_i.ready is high only in idle. The
// single 32x32 multiplier is shared by the cap check and the output product.
// A finished result is held in the output register while res_o.ready is low;
// the next command is accepted meanwhile but its result waits for that slot.
// Reset (rst_ni low, asynchronous) restores the register defaults, zeroes both
// setpoints, leaves editing off and shows four digits for each channel.

module digit_cursor_setpoint_editor (
  input  logic            clk_i,
  input  logic            rst_ni,
  dcse_cfg_if.sink        cfg_i,
  dcse_cmd_if.sink        cmd_i,
  dcse_res_if.source      res_o
);

  // configuration
  logic [2:0]         vdec_q, adec_q;
  logic signed [31:0] vlo_q, vhi_q, alo_q, ahi_q;
  logic [16:0]        cap_q;
  logic [3:0]         mind_q;

  // setpoint and cursor state
  logic [31:0] sp_q [2];
  logic [31:0] sp_d [2];
  logic        edit_q, edit_d;
  logic        chan_q, chan_d;
  logic [3:0]  cidx_q [2];
  logic [3:0]  cidx_d [2];
  logic [3:0]  cexp_q [2];
  logic [3:0]  cexp_d [2];
  logic        chosen_q [2];
  logic        chosen_d [2];
  logic [4:0]  shown_q [2];
  logic [4:0]  shown_d [2];

  // work registers
  dcse_pkg::state_e   st_q, st_d;
  dcse_pkg::cmd_e     cmd_q, cmd_d;
  logic               ch_q, ch_d;
  logic [31:0]        nv_q, nv_d;
  logic signed [32:0] cand_q, cand_d;
  logic [63:0]        acc_q, acc_d;
  logic [63:0]        prod_q, prod_d;
  logic               neg_q, neg_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [3:0]         len_q, len_d;

  // result register
  logic        ov_q, ov_d;
  logic [31:0] ovv_q, ovv_d, oav_q, oav_d;
  logic [63:0] opp_q, opp_d;
  logic        oed_q, oed_d, och_q, och_d;
  logic [3:0]  ocd_q, ocd_d, ose_q, ose_d;
  logic [4:0]  odt_q, odt_d;

  // shared arithmetic
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        div_start, div_done;
  logic [63:0] div_quot;
  logic [31:0] other_mag;

  logic [2:0]         dec;
  logic [31:0]        mag_c, mag_n, cval, bnd;
  logic [63:0]        delta, sum;
  logic signed [32:0] lo33, hi33, c33;
  logic [4:0]         tot, tm1, mi, pidx;
  logic [3:0]         intlen;
  logic               mine, is_up;

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = (st_q == dcse_pkg::ST_IDLE);

  assign other_mag = dcse_pkg::mag32(sp_q[~ch_q]);
  assign mul_a = (st_q == dcse_pkg::ST_CMUL) ? dcse_pkg::mag32(cand_q[31:0])
                                             : dcse_pkg::mag32(sp_q[0]);
  assign mul_b = (st_q == dcse_pkg::ST_CMUL) ? other_mag : dcse_pkg::mag32(sp_q[1]);
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  dcse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (other_mag),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    st_d      = st_q;
    cmd_d     = cmd_q;
    ch_d      = ch_q;
    nv_d      = nv_q;
    cand_d    = cand_q;
    acc_d     = acc_q;
    prod_d    = prod_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    sp_d      = sp_q;
    edit_d    = edit_q;
    chan_d    = chan_q;
    cidx_d    = cidx_q;
    cexp_d    = cexp_q;
    chosen_d  = chosen_q;
    shown_d   = shown_q;
    ov_d      = ov_q;
    ovv_d     = ovv_q;
    oav_d     = oav_q;
    opp_d     = opp_q;
    oed_d     = oed_q;
    och_d     = och_q;
    ocd_d     = ocd_q;
    odt_d     = odt_q;
    ose_d     = ose_q;
    div_start = 1'b0;

    dec   = ch_q ? adec_q : vdec_q;
    mine  = edit_q && (chan_q == ch_q);
    is_up = (cmd_q == dcse_pkg::CMD_UP);
    mag_c = dcse_pkg::mag32(sp_q[ch_q]);
    delta = chosen_q[ch_q] ? dcse_pkg::pow10({1'b0, cexp_q[ch_q]})
                           : dcse_pkg::pow10({2'b00, dec});
    sum   = {32'd0, mag_c} + delta;
    mag_n = mag_c;
    tot   = shown_q[ch_q];
    tm1   = tot - 5'd1;
    mi    = 5'd0;
    lo33  = ch_q ? {alo_q[31], alo_q} : {vlo_q[31], vlo_q};
    hi33  = ch_q ? {ahi_q[31], ahi_q} : {vhi_q[31], vhi_q};
    c33   = cand_q;
    cval  = 32'd0;
    bnd   = 32'd0;
    pidx  = {2'b00, dec} + {1'b0, cnt_q};
    intlen = (len_q < mind_q) ? mind_q : len_q;

    if (res_o.ready) begin
      ov_d = 1'b0;
    end

    if (cfg_i.valid) begin
      unique case (dcse_pkg::reg_e'(cfg_i.index))
        dcse_pkg::REG_VOLT_DEC:  ;
        dcse_pkg::REG_AMP_DEC:   ;
        dcse_pkg::REG_VOLT_LO:   ;
        dcse_pkg::REG_VOLT_HI:   ;
        dcse_pkg::REG_AMP_LO:    ;
        dcse_pkg::REG_AMP_HI:    ;
        dcse_pkg::REG_POWER_CAP: ;
        dcse_pkg::REG_MIN_INT:   ;
        default:                 ;
      endcase
    end

    unique case (st_q)
      dcse_pkg::ST_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d = dcse_pkg::cmd_e'(cmd_i.command);
          ch_d  = cmd_i.channel;
          nv_d  = cmd_i.new_value;
          st_d  = dcse_pkg::ST_EXEC;
        end
      end
      dcse_pkg::ST_EXEC: begin
        st_d = dcse_pkg::ST_PROD;
        case (cmd_q) inside
          dcse_pkg::CMD_START: begin
            if (!mine) begin
              edit_d   = 1'b1;
              chan_d   = ch_q;
              cexp_d[ch_q]   = {1'b0, dec};
              chosen_d[ch_q] = 1'b1;
              cidx_d[ch_q]   = 4'd0;
              len_d = 4'd1;
              cnt_d = 4'd1;
              st_d  = dcse_pkg::ST_RLOOP;
            end
          end
          dcse_pkg::CMD_LEFT, dcse_pkg::CMD_RIGHT: begin
            if (mine) begin
              if (cmd_q == dcse_pkg::CMD_LEFT) begin
                mi = (cidx_q[ch_q] == 4'd0) ? 5'd0 : {1'b0, cidx_q[ch_q]} - 5'd1;
              end else begin
                mi = {1'b0, cidx_q[ch_q]} + 5'd1;
              end
              if (mi > tm1) begin
                mi = tm1;
              end
              cidx_d[ch_q] = mi[3:0];
              cexp_d[ch_q] = 4'(tm1 - mi);
            end
          end
          dcse_pkg::CMD_UP, dcse_pkg::CMD_DOWN: begin
            if (mine) begin
              if (is_up) begin
                mag_n = (sum <= dcse_pkg::MAG_MAX_POS) ? sum[31:0] : mag_c;
              end else begin
                mag_n = ({32'd0, mag_c} >= delta) ? mag_c - delta[31:0] : 32'd0;
              end
              cand_d = sp_q[ch_q][31] ? (33'sd0 - $signed({1'b0, mag_n}))
                                      : $signed({1'b0, mag_n});
              st_d = dcse_pkg::ST_LIMIT;
            end
          end
          dcse_pkg::CMD_END: begin
            if (mine) begin
              edit_d = 1'b0;
            end
          end
          dcse_pkg::CMD_SET: begin
            cand_d = $signed({nv_q[31], nv_q});
            st_d   = dcse_pkg::ST_LIMIT;
          end
          default: ;
        endcase
      end
      dcse_pkg::ST_LIMIT: begin
        if (cmd_q == dcse_pkg::CMD_SET) begin
          if (c33 < lo33) c33 = lo33;
          if (c33 > hi33) c33 = hi33;
        end else begin
          if (c33 > hi33) c33 = hi33;
          if (c33 < lo33) c33 = lo33;
        end
        cval = c33[31:0];
        if (cap_q == 17'd0) begin
          sp_d[ch_q] = cval;
          len_d = 4'd1;
          cnt_d = 4'd1;
          st_d  = dcse_pkg::ST_RLOOP;
        end else begin
          cand_d = $signed({cval[31], cval});
          acc_d  = {47'd0, cap_q};
          cnt_d  = {1'b0, vdec_q} + {1'b0, adec_q};
          st_d   = dcse_pkg::ST_CSCL;
        end
      end
      dcse_pkg::ST_CSCL: begin
        if (cnt_q == 4'd0) begin
          st_d = dcse_pkg::ST_CMUL;
        end else begin
          acc_d = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0};
          cnt_d = cnt_q - 4'd1;
        end
      end
      dcse_pkg::ST_CMUL: begin
        prod_d = mul_p;
        st_d   = dcse_pkg::ST_CCHK;
      end
      dcse_pkg::ST_CCHK: begin
        if (prod_q <= acc_q) begin
          sp_d[ch_q] = cand_q[31:0];
          len_d = 4'd1;
          cnt_d = 4'd1;
          st_d  = dcse_pkg::ST_RLOOP;
        end else begin
          div_start = 1'b1;
          st_d = dcse_pkg::ST_CDIV;
        end
      end
      dcse_pkg::ST_CDIV: begin
        if (div_done) begin
          acc_d = div_quot;
          st_d  = dcse_pkg::ST_CSAT;
        end
      end
      dcse_pkg::ST_CSAT: begin
        if (cand_q[32]) begin
          bnd = (acc_q > dcse_pkg::INT32_MAG_MIN) ? dcse_pkg::INT32_MAG_MIN[31:0]
                                                   : acc_q[31:0];
          sp_d[ch_q] = 32'd0 - bnd;
        end else begin
          sp_d[ch_q] = (acc_q > dcse_pkg::MAG_MAX_POS) ? dcse_pkg::MAG_MAX_POS[31:0]
                                                       : acc_q[31:0];
        end
        len_d = 4'd1;
        cnt_d = 4'd1;
        st_d  = dcse_pkg::ST_RLOOP;
      end
      dcse_pkg::ST_RLOOP: begin
        if ({32'd0, mag_c} >= dcse_pkg::pow10(pidx)) begin
          len_d = len_q + 4'd1;
        end
        if (cnt_q == dcse_pkg::RENDER_STEPS) begin
          st_d = dcse_pkg::ST_RFIN;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      dcse_pkg::ST_RFIN: begin
        tot = {1'b0, intlen} + {2'b00, dec};
        if (tot > 5'(dcse_pkg::MAX_DIGITS)) begin
          tot = 5'(dcse_pkg::MAX_DIGITS);
        end
        tm1 = tot - 5'd1;
        shown_d[ch_q] = tot;
        if (chosen_q[ch_q] && ({1'b0, cexp_q[ch_q]} <= tm1)) begin
          cidx_d[ch_q] = 4'(tm1 - {1'b0, cexp_q[ch_q]});
        end
        st_d = dcse_pkg::ST_PROD;
      end
      dcse_pkg::ST_PROD: begin
        prod_d = mul_p;
        neg_d  = sp_q[0][31] ^ sp_q[1][31];
        st_d   = dcse_pkg::ST_DONE;
      end
      dcse_pkg::ST_DONE: begin
        if (!ov_q || res_o.ready) begin
          ov_d  = 1'b1;
          ovv_d = sp_q[0];
          oav_d = sp_q[1];
          opp_d = neg_q ? (64'd0 - prod_q) : prod_q;
          oed_d = edit_q;
          och_d = edit_q ? chan_q : 1'b0;
          ocd_d = edit_q ? cidx_q[chan_q] : 4'd0;
          odt_d = edit_q ? shown_q[chan_q] : 5'd0;
          ose_d = edit_q ? cexp_q[chan_q] : 4'd0;
          st_d  = dcse_pkg::ST_IDLE;
        end
      end
      default: st_d = dcse_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vdec_q <= 3'd2;
      adec_q <= 3'd2;
      vlo_q  <= 32'sd0;
      vhi_q  <= 32'sd6000;
      alo_q  <= 32'sd0;
      ahi_q  <= 32'sd2000;
      cap_q  <= 17'd180;
      mind_q <= 4'd2;
    end else if (cfg_i.valid) begin
      case (dcse_pkg::reg_e'(cfg_i.index))
        dcse_pkg::REG_VOLT_DEC:  vdec_q <= cfg_i.data[2:0];
        dcse_pkg::REG_AMP_DEC:   adec_q <= cfg_i.data[2:0];
        dcse_pkg::REG_VOLT_LO:   vlo_q  <= cfg_i.data;
        dcse_pkg::REG_VOLT_HI:   vhi_q  <= cfg_i.data;
        dcse_pkg::REG_AMP_LO:    alo_q  <= cfg_i.data;
        dcse_pkg::REG_AMP_HI:    ahi_q  <= cfg_i.data;
        dcse_pkg::REG_POWER_CAP: cap_q  <= cfg_i.data[16:0];
        dcse_pkg::REG_MIN_INT:   mind_q <= cfg_i.data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= dcse_pkg::ST_IDLE;
      cmd_q    <= dcse_pkg::CMD_START;
      ch_q     <= 1'b0;
      nv_q     <= '0;
      cand_q   <= '0;
      acc_q    <= '0;
      prod_q   <= '0;
      neg_q    <= 1'b0;
      cnt_q    <= '0;
      len_q    <= '0;
      sp_q     <= '{default: '0};
      edit_q   <= 1'b0;
      chan_q   <= 1'b0;
      cidx_q   <= '{default: '0};
      cexp_q   <= '{default: '0};
      chosen_q <= '{default: 1'b0};
      shown_q  <= '{default: 5'd4};
      ov_q     <= 1'b0;
      ovv_q    <= '0;
      oav_q    <= '0;
      opp_q    <= '0;
      oed_q    <= 1'b0;
      och_q    <= 1'b0;
      ocd_q    <= '0;
      odt_q    <= '0;
      ose_q    <= '0;
    end else begin
      st_q     <= st_d;
      cmd_q    <= cmd_d;
      ch_q     <= ch_d;
      nv_q     <= nv_d;
      cand_q   <= cand_d;
      acc_q    <= acc_d;
      prod_q   <= prod_d;
      neg_q    <= neg_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      sp_q     <= sp_d;
      edit_q   <= edit_d;
      chan_q   <= chan_d;
      cidx_q   <= cidx_d;
      cexp_q   <= cexp_d;
      chosen_q <= chosen_d;
      shown_q  <= shown_d;
      ov_q     <= ov_d;
      ovv_q    <= ovv_d;
      oav_q    <= oav_d;
      opp_q    <= opp_d;
      oed_q    <= oed_d;
      och_q    <= och_d;
      ocd_q    <= ocd_d;
      odt_q    <= odt_d;
      ose_q    <= ose_d;
    end
  end

  assign res_o.valid          = ov_q;
  assign res_o.volt_value     = ovv_q;
  assign res_o.amp_value      = oav_q;
  assign res_o.power_product  = opp_q;
  assign res_o.is_editing     = oed_q;
  assign res_o.edited_channel = och_q;
  assign res_o.cursor_digit   = ocd_q;
  assign res_o.digit_total    = odt_q;
  assign res_o.step_exponent  = ose_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready)
    else $error("command accepted while a transaction is in flight");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q))
    else $error("sequencer state not one-hot");

  a_idle_cursor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.is_editing) |->
      (res_o.digit_total == 5'd0 && res_o.cursor_digit == 4'd0 &&
       res_o.step_exponent == 4'd0 && !res_o.edited_channel))
    else $error("cursor fields set while not editing");

  a_digit_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.is_editing) |->
      (res_o.digit_total != 5'd0 && res_o.digit_total <= 5'(dcse_pkg::MAX_DIGITS)))
    else $error("shown digit count out of range");

endmodule
